// File: rtl/ism_pkg.sv
// package for the interval sort and merge block
// shared constants, codes, state and command types; no dependencies
`timescale 1ns / 1ps

package ism_pkg;

    localparam int MaxRanges = 64;
    localparam int IdxW      = $clog2(MaxRanges);
    localparam int CntW      = $clog2(MaxRanges + 1);
    localparam int ValW      = 32;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_BAD_RANGE = 2'd1;
    localparam status_t STATUS_OVERFLOW  = 2'd2;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_SORT_SHIFT,
        ST_SORT_PLACE,
        ST_MRG_FIRST,
        ST_MRG_RD,
        ST_MRG_CMP,
        ST_EMIT,
        ST_EMIT_LAST,
        ST_ERR
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic            store_in;   // write input item at count
        logic            rd_en;      // registered read at rd_addr
        logic [IdxW-1:0] rd_addr;
        logic            hold_key;   // capture read data as the key
        logic            shift_wr;   // write read data at wr_addr
        logic            place_wr;   // write key at wr_addr
        logic [IdxW-1:0] wr_addr;
        logic            cur_load;   // current merged range from read data
        logic            cur_ext;    // raise current end
        logic            out_load;   // load output register
        logic            out_last;
        logic            out_err;
        logic            clear_set;
    } ism_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic            prev_gt_key;  // read start above held key
        logic            rd_overlaps;  // read start at or below current end
        logic [CntW-1:0] count;
        status_t         err;
    } ism_stat_t;

endpackage

// File: rtl/interval_sort_and_merge_top.sv
// channel     | dir | tdata fields (low bit up)             | tuser / tlast
// s_axis      | in  | range_start[31:0], range_end[63:32]    | tlast = last_range
// m_axis      | out | merged_start[31:0], merged_end[63:32]  | tlast = last_merged, tuser = status
// cfg         | in  | cfg_wdata = check_inputs               | cfg_wen
// loading takes one cycle per range; after the last range the check state looks for an
// error and sends it as a single last result; otherwise an insertion sort on the range
// memory orders the ranges by start, shifting larger entries up, and a sweep then
// merges overlapping ranges and emits each merged range as a result.
// the input is held off (s_axis_tready low) from the last range until the
// last result is loaded; a stalled m_axis holds the sweep. reset is synchronous.
// depends on ism_pkg, ism_ctrl, ism_datapath
`timescale 1ns / 1ps

module interval_sort_and_merge_top import ism_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic        cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // range_start, range_end
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // merged_start, merged_end
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // status
);

    logic      check_reg;
    ism_cmd_t  cmd;
    ism_stat_t stat;
    logic signed [ValW-1:0] o_start, o_end;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_reg <= 1'b1;
        end else if (cfg_wen) begin
            check_reg <= cfg_wdata;
        end
    end

    ism_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ism_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .check_inputs (check_reg),
        .in_start     (s_axis_tdata[31:0]),
        .in_end       (s_axis_tdata[63:32]),
        .cmd          (cmd),
        .stat         (stat),
        .out_start    (o_start),
        .out_end      (o_end),
        .out_last     (m_axis_tlast),
        .out_status   (m_axis_tuser)
    );

    assign m_axis_tdata = {o_end, o_start};

endmodule

// File: rtl/ism_datapath.sv
// datapath: range memories, sort key, merge registers and output register
// depends on ism_pkg
`timescale 1ns / 1ps

module ism_datapath import ism_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   check_inputs,
    input  logic signed [ValW-1:0] in_start,
    input  logic signed [ValW-1:0] in_end,
    input  ism_cmd_t               cmd,
    output ism_stat_t              stat,
    output logic signed [ValW-1:0] out_start,
    output logic signed [ValW-1:0] out_end,
    output logic                   out_last,
    output status_t                out_status
);

    logic signed [ValW-1:0] start_mem [MaxRanges];
    logic signed [ValW-1:0] end_mem   [MaxRanges];
    logic signed [ValW-1:0] rd_start_reg, rd_end_reg;
    logic signed [ValW-1:0] key_start_reg, key_end_reg;
    logic signed [ValW-1:0] cur_start_reg, cur_end_reg;
    logic [CntW-1:0]        count_reg, count_next;
    status_t                err_reg, err_next;
    logic                   wr_en;
    logic [IdxW-1:0]        wr_idx;
    logic signed [ValW-1:0] wr_start, wr_end;
    logic                   full;

    assign full = (count_reg == CntW'(MaxRanges));

    // memory write select
    always_comb begin
        wr_en    = 1'b0;
        wr_idx   = cmd.wr_addr;
        wr_start = rd_start_reg;
        wr_end   = rd_end_reg;
        if (cmd.store_in) begin
            wr_en    = !full;
            wr_idx   = count_reg[IdxW-1:0];
            wr_start = in_start;
            wr_end   = in_end;
        end else if (cmd.shift_wr) begin
            wr_en = 1'b1;
        end else if (cmd.place_wr) begin
            wr_en    = 1'b1;
            wr_start = key_start_reg;
            wr_end   = key_end_reg;
        end
    end

    // range memories, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            start_mem[wr_idx] <= wr_start;
            end_mem[wr_idx]   <= wr_end;
        end
        if (cmd.rd_en) begin
            rd_start_reg <= start_mem[cmd.rd_addr];
            rd_end_reg   <= end_mem[cmd.rd_addr];
        end
    end

    // fill count and first error
    always_comb begin
        count_next = count_reg;
        err_next   = err_reg;
        if (cmd.store_in) begin
            if (full) begin
                if (err_reg == STATUS_OK) err_next = STATUS_OVERFLOW;
            end else begin
                count_next = count_reg + CntW'(1);
                if (check_inputs && (in_start > in_end) && err_reg == STATUS_OK)
                    err_next = STATUS_BAD_RANGE;
            end
        end
        if (cmd.clear_set) begin
            count_next = '0;
            err_next   = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            err_reg   <= STATUS_OK;
        end else begin
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    // sort key and merge registers
    always_ff @(posedge aclk) begin
        if (cmd.hold_key) begin
            key_start_reg <= rd_start_reg;
            key_end_reg   <= rd_end_reg;
        end
        if (cmd.cur_load) begin
            cur_start_reg <= rd_start_reg;
            cur_end_reg   <= rd_end_reg;
        end else if (cmd.cur_ext && cur_end_reg < rd_end_reg) begin
            cur_end_reg <= rd_end_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_start  <= cmd.out_err ? '0 : cur_start_reg;
            out_end    <= cmd.out_err ? '0 : cur_end_reg;
            out_last   <= cmd.out_last;
            out_status <= cmd.out_err ? err_reg : STATUS_OK;
        end
    end

    assign stat.prev_gt_key = rd_start_reg > key_start_reg;
    assign stat.rd_overlaps = rd_start_reg <= cur_end_reg;
    assign stat.count       = count_reg;
    assign stat.err         = err_reg;

    // count never passes the store depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(MaxRanges))
        else $error("range count above depth");

    // overflow only recorded with a full store
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg == STATUS_OK && err_next == STATUS_OVERFLOW && !cmd.clear_set)
        |-> full)
        else $error("overflow without full store");

    // a clear empties the set
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_set |=> (count_reg == '0 && err_reg == STATUS_OK))
        else $error("set not cleared");

endmodule

// File: rtl/ism_ctrl.sv
// controller: load, insertion sort, merge sweep and result handshake
// depends on ism_pkg
`timescale 1ns / 1ps

module ism_ctrl import ism_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  logic      in_last,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  ism_stat_t stat,
    output ism_cmd_t  cmd
);

    state_t          state_reg, state_next;
    logic [CntW-1:0] i_reg, i_next;   // outer index / sweep index
    logic [CntW-1:0] j_reg, j_next;   // insertion position
    logic            ov_reg, ov_next;
    logic            in_xfer, out_free;

    assign out_free  = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign in_ready  = (state_reg == ST_LOAD);
    assign in_xfer   = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            i_reg     <= '0;
            j_reg     <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            ov_reg    <= ov_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        case (state_reg)
            ST_LOAD: begin
                cmd.store_in = in_xfer;
                if (in_xfer && in_last) begin
                    state_next = ST_ERR;   // error check after the store settles
                end
            end
            ST_ERR: begin
                if (stat.err != STATUS_OK) begin
                    if (out_free) begin
                        cmd.out_load  = 1'b1;
                        cmd.out_err   = 1'b1;
                        cmd.out_last  = 1'b1;
                        cmd.clear_set = 1'b1;
                        ov_next       = 1'b1;
                        state_next    = ST_LOAD;
                    end
                end else begin
                    i_next     = CntW'(1);
                    state_next = ST_SORT_RD;
                end
            end
            ST_SORT_RD: begin
                if (i_reg >= stat.count) begin
                    i_next      = '0;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = '0;
                    state_next  = ST_MRG_FIRST;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = i_reg[IdxW-1:0];
                    j_next      = i_reg;
                    state_next  = ST_SORT_CMP;
                end
            end
            ST_SORT_CMP: begin
                // key captured; read neighbour below
                cmd.hold_key = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rd_addr  = IdxW'(j_reg - CntW'(1));
                state_next   = ST_SORT_SHIFT;
            end
            ST_SORT_SHIFT: begin
                if (stat.prev_gt_key) begin
                    cmd.shift_wr = 1'b1;
                    cmd.wr_addr  = j_reg[IdxW-1:0];
                    j_next       = j_reg - CntW'(1);
                    if (j_reg == CntW'(1)) begin
                        state_next = ST_SORT_PLACE;
                    end else begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = IdxW'(j_reg - CntW'(2));
                    end
                end else begin
                    state_next = ST_SORT_PLACE;
                end
            end
            ST_SORT_PLACE: begin
                cmd.place_wr = 1'b1;
                cmd.wr_addr  = j_reg[IdxW-1:0];
                i_next       = i_reg + CntW'(1);
                state_next   = ST_SORT_RD;
            end
            ST_MRG_FIRST: begin
                cmd.cur_load = 1'b1;
                i_next       = CntW'(1);
                state_next   = ST_MRG_RD;
            end
            ST_MRG_RD: begin
                if (i_reg >= stat.count) begin
                    state_next = ST_EMIT_LAST;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = i_reg[IdxW-1:0];
                    state_next  = ST_MRG_CMP;
                end
            end
            ST_MRG_CMP: begin
                if (stat.rd_overlaps) begin
                    cmd.cur_ext = 1'b1;
                    i_next      = i_reg + CntW'(1);
                    state_next  = ST_MRG_RD;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.cur_load = 1'b1;
                    ov_next      = 1'b1;
                    i_next       = i_reg + CntW'(1);
                    state_next   = ST_MRG_RD;
                end
            end
            ST_EMIT_LAST: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_last  = 1'b1;
                    cmd.clear_set = 1'b1;
                    ov_next       = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // output never overwritten while waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && ov_reg) |-> out_ready)
        else $error("result overwritten");

    // clear only with a last result
    a_clear_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_set |-> (cmd.out_load && cmd.out_last))
        else $error("clear without last result");

    // sort writes never coincide with input stores
    a_wr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store_in |-> !(cmd.shift_wr || cmd.place_wr))
        else $error("write port conflict");

endmodule

// File: sim/testbench.sv
// testbench for interval_sort_and_merge_top: range sets in, disjoint merged ranges out
// predicts each set with an insertion sort and sweep; depends on ism_pkg and the rtl
`timescale 1ns / 1ps

class merge_scoreboard;
    logic signed [31:0] start_q [$];
    logic signed [31:0] end_q [$];
    logic [1:0]         err;
    bit                 check_on;
    logic [66:0]        expected_q [$];   // {status, last, end, start}
    int                 fails;

    function new();
        err = ism_pkg::STATUS_OK;
        check_on = 1'b1;
        fails = 0;
    endfunction

    // note one accepted range transfer
    function void note_range(logic signed [31:0] s, logic signed [31:0] e, bit last);
        logic signed [31:0] ks, ke, cs, ce;
        int j;
        if (start_q.size() >= ism_pkg::MaxRanges) begin
            if (err == ism_pkg::STATUS_OK) err = ism_pkg::STATUS_OVERFLOW;
        end else begin
            if (check_on && s > e && err == ism_pkg::STATUS_OK)
                err = ism_pkg::STATUS_BAD_RANGE;
            start_q.push_back(s);
            end_q.push_back(e);
        end
        if (!last) return;
        if (err != ism_pkg::STATUS_OK) begin
            expected_q.push_back({err, 1'b1, 32'd0, 32'd0});
        end else begin
            // stable insertion sort by start
            for (int i = 1; i < start_q.size(); i++) begin
                ks = start_q[i];
                ke = end_q[i];
                j = i;
                while (j > 0 && start_q[j-1] > ks) begin
                    start_q[j] = start_q[j-1];
                    end_q[j] = end_q[j-1];
                    j--;
                end
                start_q[j] = ks;
                end_q[j] = ke;
            end
            // sweep
            cs = start_q[0];
            ce = end_q[0];
            for (int i = 1; i < start_q.size(); i++) begin
                if (start_q[i] <= ce) begin
                    if (ce < end_q[i]) ce = end_q[i];
                end else begin
                    expected_q.push_back({ism_pkg::STATUS_OK, 1'b0, ce, cs});
                    cs = start_q[i];
                    ce = end_q[i];
                end
            end
            expected_q.push_back({ism_pkg::STATUS_OK, 1'b1, ce, cs});
        end
        start_q.delete();
        end_q.delete();
        err = ism_pkg::STATUS_OK;
    endfunction

    // check one accepted result transfer
    function void check_result(logic [63:0] data, logic last, logic [1:0] status);
        logic [66:0] x;
        if (expected_q.size() == 0) begin
            $error("unexpected result start=%h end=%h", data[31:0], data[63:32]);
            fails++;
            return;
        end
        x = expected_q.pop_front();
        if (data[31:0] !== x[31:0]) begin
            $error("merged_start expected %h actual %h", x[31:0], data[31:0]);
            fails++;
        end
        if (data[63:32] !== x[63:32]) begin
            $error("merged_end expected %h actual %h", x[63:32], data[63:32]);
            fails++;
        end
        if (last !== x[64]) begin
            $error("last_merged expected %b actual %b", x[64], last);
            fails++;
        end
        if (status !== x[66:65]) begin
            $error("status expected %0d actual %0d", x[66:65], status);
            fails++;
        end
    endfunction
endclass

module testbench;
    import ism_pkg::*;

    localparam int StallLimit = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wen = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    merge_scoreboard board = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  quiet_cycles = 0;

    always #5 aclk = ~aclk;

    interval_sort_and_merge_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    // result side: random stalls, check each transfer
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no transfer
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    // one range transfer, with random idle cycles before it; tvalid stays high
    // after the transfer until the next one or a pause
    task automatic send_range(logic signed [31:0] s, logic signed [31:0] e, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {e, s};
        s_axis_tlast <= last;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_range(s, e, last);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_check(bit v);
        wait_drained();
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        board.check_on = v;
        cfg_wen <= 1'b0;
    endtask

    function automatic logic [31:0] rand_value(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(2000)) - 1000;
            default: return {16'($urandom_range(40)) - 16'd20, 16'($urandom())};
        endcase
    endfunction

    // random set of n ranges, mostly well formed
    task automatic send_set(int n);
        logic signed [31:0] a, b, t;
        int mode;
        mode = $urandom_range(2);
        for (int i = 0; i < n; i++) begin
            a = rand_value(mode);
            b = rand_value(mode);
            if ($urandom_range(9) != 0 && a > b) begin
                t = a; a = b; b = t;
            end
            send_range(a, b, i == n - 1);
        end
    endtask

    int n;

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, touching, equal starts, single range, bad range
        send_range(32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
        send_range(32'sd10, 32'sd20, 1'b0);
        send_range(32'sd20, 32'sd30, 1'b0);
        send_range(32'sd31, 32'sd40, 1'b0);
        send_range(-32'sd5, -32'sd1, 1'b0);
        send_range(32'sd31, 32'sd35, 1'b1);
        send_range(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
        send_range(32'sh8000_0000, 32'sh8000_0000, 1'b1);
        send_range(32'sd5, 32'sd3, 1'b0);
        send_range(32'sd1, 32'sd2, 1'b1);
        write_check(1'b0);
        send_range(32'sd5, 32'sd3, 1'b0);
        send_range(32'sd4, 32'sd9, 1'b0);
        send_range(32'sd20, 32'sd1, 1'b1);
        write_check(1'b1);
        // full set, overflow, then an overflow after a bad range
        send_set(MaxRanges);
        for (int i = 0; i < MaxRanges + 1; i++)
            send_range(i, i + 1, i == MaxRanges);
        send_range(32'sd9, 32'sd0, 1'b0);
        for (int i = 0; i < MaxRanges; i++)
            send_range(i, i, i == MaxRanges - 1);

        // random phases of idling
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            write_check(ph[0]);
            for (int k = 0; k < 40; k += n) begin
                n = ($urandom_range(15) == 0) ? $urandom_range(MaxRanges + 2, 30)
                                              : $urandom_range(12, 1);
                send_set(n);
                if ($urandom_range(7) == 0) wait_drained();
            end
        end
        write_check(1'b1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        if (board.fails == 0 && board.expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// File: interval_sort_and_merge_top.f
rtl/ism_pkg.sv
rtl/ism_datapath.sv
rtl/ism_ctrl.sv
rtl/interval_sort_and_merge_top.sv
sim/testbench.sv
